[src/ndva_pkg.sv]
// shared types, constants and helpers for the note duplicator voice allocator
`timescale 1ns / 1ps
`default_nettype none
package ndva_pkg;

   localparam int MAX_SLOTS         = 8;
   localparam int TRACK_WORD_W      = 64;
   localparam int MAX_TARGETS       = 128;
   localparam int NUM_SLOTS_DEF     = 8;
   localparam int NUM_TRACKS_DEF    = 64;
   localparam int NUM_TARGETS_DEF   = 128;
   localparam int CHANNELS          = 64;
   localparam logic [7:0] NOTE_CMD_FIRST = 8'd120;
   localparam logic [7:0] NOTE_TOP  = 8'd119;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [15:0] LFSR_SEED = 16'h0001;
   localparam int CSR_AW            = 5;

   // register map, index = byte address / 8
   typedef enum logic [1:0] {
      REG_MUTED,
      REG_ENABLE,
      REG_TARGET,
      REG_OFFSET
   } ndva_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VM_LOAD,
      ST_SLOT,
      ST_UPDATE,
      ST_FINISH
   } ndva_state_type;

   typedef struct packed {
      logic       command;
      logic [5:0] channel;
      logic [7:0] note;
      logic [7:0] instrument;
      logic [7:0] effect_cmd;
      logic [7:0] effect_param;
   } ndva_req_type;

   typedef struct packed {
      logic [6:0] target_machine;
      logic [5:0] target_track;
      logic [7:0] out_note;
      logic [7:0] out_instrument;
      logic [7:0] out_effect_cmd;
      logic [7:0] out_effect_param;
      logic       last;
   } ndva_rsp_type;

   // slot settings seen by the back end
   typedef struct packed {
      logic [7:0]  enable;
      logic [55:0] target;
      logic [55:0] offset;
   } ndva_cfg_type;

   // head of the queue between front and back
   typedef struct packed {
      logic         valid;
      ndva_req_type item;
   } ndva_queue_type;

   // voice map entry of one slot
   typedef struct packed {
      logic       valid;
      logic [5:0] track;
   } ndva_voice_type;

   // lowest set bit of a track word
   function automatic logic [5:0] first_one64(input logic [63:0] v);
      logic [5:0] r;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) begin
            r = 6'(i);
         end
      end
      return r;
   endfunction

   // lowest set bit of a slot mask
   function automatic logic [2:0] first_one8(input logic [7:0] v);
      logic [2:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/ndva_front.sv]
// front end: takes words, drops muted notes and queues the rest
`timescale 1ns / 1ps
`default_nettype none
module ndva_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ndva_pkg::ndva_req_type req_data,
   input  wire logic                  muted,
   input  wire logic                  pop,
   output ndva_pkg::ndva_queue_type   head
);
   import ndva_pkg::*;

   ndva_req_type q_mem [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         accept;
   logic         push;
   logic         do_pop;

   // stop always goes through, notes only when not muted
   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_data.command || !muted);
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= req_data;
      end
   end

endmodule
`default_nettype wire

[src/ndva_back.sv]
// back end: per-slot voice allocation, transpose and result output
`timescale 1ns / 1ps
`default_nettype none
module ndva_back #(
   parameter int NUM_SLOTS   = ndva_pkg::NUM_SLOTS_DEF,
   parameter int NUM_TRACKS  = ndva_pkg::NUM_TRACKS_DEF,
   parameter int NUM_TARGETS = ndva_pkg::NUM_TARGETS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ndva_pkg::ndva_cfg_type  cfg,
   input  wire ndva_pkg::ndva_queue_type head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output ndva_pkg::ndva_rsp_type       rsp_data
);
   import ndva_pkg::*;

   localparam int TgtW = $clog2(NUM_TARGETS);
   localparam logic [63:0] TrackMask =
      (NUM_TRACKS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_TRACKS) - 64'd1);
   localparam logic [5:0] HalfTracks = 6'(NUM_TRACKS / 2);

   ndva_state_type state_ff, state_in;

   logic [55:0]  vm_mem [CHANNELS];
   logic [63:0]  tf_mem [NUM_TARGETS];
   logic [CHANNELS-1:0]    vm_vld_ff;
   logic [NUM_TARGETS-1:0] tf_vld_ff;
   logic [55:0]  vm_rd_ff;
   logic         vm_rd_vld_ff;
   logic [63:0]  tf_rd_ff;
   logic         tf_rd_vld_ff;

   ndva_req_type item_ff;
   ndva_voice_type [MAX_SLOTS-1:0] row_ff;
   logic [7:0]   pending_ff;
   logic [2:0]   slot_ff;
   logic         last_ff;
   logic [15:0]  lfsr_ff;
   ndva_rsp_type rsp_ff;
   logic         rsp_valid_ff;

   // control strobes
   logic clear_all, load_item, vm_rd_en, load_row, take_slot, do_update, vm_wr;
   logic out_free;

   // slot selection
   logic [7:0]  eligible;
   logic [2:0]  pick;
   logic [6:0]  pick_tgt;
   logic [6:0]  cur_tgt;
   logic [6:0]  cur_off;

   // update datapath
   ndva_voice_type entry;
   logic [63:0] free_w;
   logic [63:0] up_w;
   logic [15:0] lfsr_nx;
   logic [21:0] prod;
   logic        use_lfsr;
   logic [5:0]  trk;
   logic [63:0] trk_bit;
   logic        note_cmd;
   logic [63:0] new_free;
   logic signed [9:0] sum;
   logic [7:0]  onote;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // slots that are enabled, present and aimed at a real target
   always_comb begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
         eligible[s] = cfg.enable[s] && (s < NUM_SLOTS) &&
                       ({1'b0, cfg.target[7*s +: 7]} < 8'(NUM_TARGETS));
      end
   end

   assign pick     = first_one8(pending_ff);
   assign pick_tgt = cfg.target[7*pick +: 7];
   assign cur_tgt  = cfg.target[7*slot_ff +: 7];
   assign cur_off  = cfg.offset[7*slot_ff +: 7];

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      clear_all = 1'b0;
      load_item = 1'b0;
      vm_rd_en  = 1'b0;
      load_row  = 1'b0;
      take_slot = 1'b0;
      do_update = 1'b0;
      vm_wr     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               load_item = 1'b1;
               if (head.item.command) begin
                  clear_all = 1'b1;
               end else begin
                  vm_rd_en = 1'b1;
                  state_in = ST_VM_LOAD;
               end
            end
         end
         ST_VM_LOAD: begin
            load_row = 1'b1;
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            if (pending_ff == 8'd0) begin
               state_in = ST_FINISH;
            end else begin
               take_slot = 1'b1;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               do_update = 1'b1;
               state_in  = ST_SLOT;
            end
         end
         ST_FINISH: begin
            vm_wr    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // allocation, release and transpose for the current slot
   always_comb begin
      entry    = row_ff[slot_ff];
      free_w   = (tf_rd_vld_ff ? tf_rd_ff : {64{1'b1}}) & TrackMask;
      up_w     = free_w & ({64{1'b1}} << item_ff.channel);
      lfsr_nx  = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
      prod     = lfsr_nx * HalfTracks;
      use_lfsr = !entry.valid && (free_w == 64'd0);
      if (entry.valid) begin
         trk = entry.track;
      end else if (up_w != 64'd0) begin
         trk = first_one64(up_w);
      end else if (free_w != 64'd0) begin
         trk = first_one64(free_w);
      end else begin
         trk = prod[21:16];
      end
      trk_bit  = 64'd1 << trk;
      note_cmd = (item_ff.note >= NOTE_CMD_FIRST);
      new_free = (free_w & ~(entry.valid ? 64'd0 : trk_bit)) |
                 (note_cmd ? trk_bit : 64'd0);
      sum = signed'({2'b00, item_ff.note}) + 10'(signed'(cur_off));
      if (note_cmd) begin
         onote = item_ff.note;
      end else if (sum > signed'({2'b00, NOTE_TOP})) begin
         onote = NOTE_TOP;
      end else if (sum < 10'sd0) begin
         onote = 8'd0;
      end else begin
         onote = sum[7:0];
      end
   end

   // control registers of the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         vm_vld_ff    <= '0;
         tf_vld_ff    <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 8'd0;
      end else begin
         if (clear_all) begin
            vm_vld_ff <= '0;
            tf_vld_ff <= '0;
         end else begin
            if (vm_wr) begin
               vm_vld_ff[item_ff.channel] <= 1'b1;
            end
            if (do_update) begin
               tf_vld_ff[cur_tgt[TgtW-1:0]] <= 1'b1;
            end
         end
         if (do_update && use_lfsr) begin
            lfsr_ff <= lfsr_nx;
         end
         if (do_update) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load_row) begin
            pending_ff <= eligible;
         end else if (take_slot) begin
            pending_ff <= pending_ff & ~(8'd1 << pick);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_item) begin
         item_ff <= head.item;
      end
      if (vm_rd_en) begin
         vm_rd_ff     <= vm_mem[head.item.channel];
         vm_rd_vld_ff <= vm_vld_ff[head.item.channel];
      end
      if (load_row) begin
         row_ff <= vm_rd_vld_ff ? vm_rd_ff : 56'd0;
      end else if (do_update) begin
         row_ff[slot_ff] <= '{valid: !note_cmd, track: trk};
      end
      if (take_slot) begin
         slot_ff      <= pick;
         last_ff      <= ((pending_ff & ~(8'd1 << pick)) == 8'd0);
         tf_rd_ff     <= tf_mem[pick_tgt[TgtW-1:0]];
         tf_rd_vld_ff <= tf_vld_ff[pick_tgt[TgtW-1:0]];
      end
      if (do_update) begin
         rsp_ff.target_machine   <= cur_tgt;
         rsp_ff.target_track     <= trk;
         rsp_ff.out_note         <= onote;
         rsp_ff.out_instrument   <= item_ff.instrument;
         rsp_ff.out_effect_cmd   <= item_ff.effect_cmd;
         rsp_ff.out_effect_param <= item_ff.effect_param;
         rsp_ff.last             <= last_ff;
      end
   end

   // voice map and free-track memories
   always_ff @(posedge clock) begin
      if (vm_wr) begin
         vm_mem[item_ff.channel] <= row_ff;
      end
      if (do_update) begin
         tf_mem[cur_tgt[TgtW-1:0]] <= new_free;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[src/note_duplicator_voice_allocator.sv]
// Note duplicator voice allocator: copies note words to up to eight target machines.
// Each note word gives one result per eligible slot, in slot order, each from one
// free-track memory read-modify-write; a stalled result holds the back end in its update.
// The back end also picks up the word, loads the voice-map row, checks for the end and writes back.
// A stop word releases all voices without a result; a two-word queue lets input run ahead of the back end.
// Synchronous reset: all voices released, all tracks free, lfsr seeded to 1, regs 0.
`timescale 1ns / 1ps
`default_nettype none
module note_duplicator_voice_allocator #(
   parameter int NUM_SLOTS   = ndva_pkg::NUM_SLOTS_DEF,
   parameter int NUM_TRACKS  = ndva_pkg::NUM_TRACKS_DEF,
   parameter int NUM_TARGETS = ndva_pkg::NUM_TARGETS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire ndva_pkg::ndva_req_type       req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output ndva_pkg::ndva_rsp_type            rsp_data,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [ndva_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [63:0]                  csr_pwdata,
   output logic [63:0]                       csr_prdata,
   output logic                              csr_pready
);
   import ndva_pkg::*;

   logic         muted_ff;
   logic [7:0]   enable_ff;
   logic [55:0]  target_ff;
   logic [55:0]  offset_ff;
   ndva_reg_type csr_reg;
   logic         csr_wr;
   ndva_cfg_type cfg;
   ndva_queue_type head;
   logic         pop;

   // register file
   assign csr_pready = 1'b1;
   assign csr_reg    = ndva_reg_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         muted_ff  <= 1'b0;
         enable_ff <= 8'd0;
         target_ff <= 56'd0;
         offset_ff <= 56'd0;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_MUTED:  muted_ff  <= csr_pwdata[0];
            REG_ENABLE: enable_ff <= csr_pwdata[7:0];
            REG_TARGET: target_ff <= csr_pwdata[55:0];
            REG_OFFSET: offset_ff <= csr_pwdata[55:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_MUTED:  csr_prdata = {63'd0, muted_ff};
         REG_ENABLE: csr_prdata = {56'd0, enable_ff};
         REG_TARGET: csr_prdata = {8'd0, target_ff};
         REG_OFFSET: csr_prdata = {8'd0, offset_ff};
         default:    csr_prdata = 64'd0;
      endcase
   end

   assign cfg.enable = enable_ff;
   assign cfg.target = target_ff;
   assign cfg.offset = offset_ff;

   // front end and queue
   ndva_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .muted     (muted_ff),
      .pop       (pop),
      .head      (head)
   );

   // back end
   ndva_back #(
      .NUM_SLOTS   (NUM_SLOTS),
      .NUM_TRACKS  (NUM_TRACKS),
      .NUM_TARGETS (NUM_TARGETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // allocated track always lies inside the track range
   a_track_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_data.target_track} < 8'(NUM_TRACKS)))
      else $error("target track out of range");

   // results only go to real targets
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.target_machine} < 8'(NUM_TARGETS)))
      else $error("target machine out of range");

   // a full front queue always shows a word to the back end
   a_queue_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> head.valid)
      else $error("queue full without a head word");

   // a stalled result word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed");

endmodule
`default_nettype wire

[sim/tb_note_duplicator_voice_allocator.sv]
// testbench for the note duplicator voice allocator: random and directed words with a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_note_duplicator_voice_allocator;
   import ndva_pkg::*;

   // mirror of the block: voice map, free tracks, lfsr and slot settings
   class voice_scoreboard;
      logic        muted;
      logic [7:0]  enable;
      logic [55:0] target;
      logic [55:0] offset;
      logic        vvalid[64][8];
      logic [5:0]  vtrack[64][8];
      logic [63:0] free_mask[128];
      logic [15:0] lfsr;
      ndva_rsp_type pending[$];
      int errors;

      function new();
         muted = 0; enable = 0; target = 0; offset = 0; lfsr = LFSR_SEED;
         errors = 0;
         release_all();
      endfunction

      function void release_all();
         for (int c = 0; c < 64; c++)
            for (int s = 0; s < 8; s++) begin
               vvalid[c][s] = 0;
               vtrack[c][s] = 0;
            end
         for (int t = 0; t < 128; t++) free_mask[t] = '1;
      endfunction

      function void set_reg(ndva_reg_type idx, logic [63:0] v);
         case (idx)
            REG_MUTED: muted = v[0];
            REG_ENABLE: enable = v[7:0];
            REG_TARGET: target = v[55:0];
            default: offset = v[55:0];
         endcase
      endfunction

      function void note_word(ndva_req_type w);
         ndva_rsp_type r;
         logic [6:0] tgt;
         logic [6:0] raw;
         int j, v, n;
         logic [7:0] onote;
         if (w.command) begin
            release_all();
            return;
         end
         if (muted) return;
         n = 0;
         for (int s = 0; s < 8; s++) begin
            if (!enable[s]) continue;
            tgt = target[7*s +: 7];
            if (!vvalid[w.channel][s]) begin
               j = w.channel;
               while (j < 64 && !free_mask[tgt][j]) j++;
               if (j >= 64) begin
                  j = 0;
                  while (j < 64 && !free_mask[tgt][j]) j++;
                  if (j >= 64) begin
                     lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                     j = (int'(lfsr) * 32) >> 16;
                  end
               end
               vvalid[w.channel][s] = 1;
               vtrack[w.channel][s] = j[5:0];
               free_mask[tgt][j[5:0]] = 0;
            end
            onote = w.note;
            if (w.note < NOTE_CMD_FIRST) begin
               raw = offset[7*s +: 7];
               v = int'(w.note) + int'($signed(raw));
               if (v >= 120) v = 119;
               else if (v < 0) v = 0;
               onote = v[7:0];
            end
            r.target_machine = tgt;
            r.target_track = vtrack[w.channel][s];
            r.out_note = onote;
            r.out_instrument = w.instrument;
            r.out_effect_cmd = w.effect_cmd;
            r.out_effect_param = w.effect_param;
            r.last = 0;
            pending.push_back(r);
            n++;
            if (onote >= NOTE_CMD_FIRST && vvalid[w.channel][s]) begin
               free_mask[tgt][vtrack[w.channel][s]] = 1;
               vvalid[w.channel][s] = 0;
            end
         end
         if (n > 0) pending[pending.size()-1].last = 1;
      endfunction

      function void check_result(ndva_rsp_type got);
         ndva_rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   ndva_req_type req_data = '0;
   logic rsp_valid, rsp_stall = 0;
   ndva_rsp_type rsp_data;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;

   voice_scoreboard board = new();
   int send_idle = 0, recv_stall = 0, hold_off = 0;
   int cycles = 0;

   note_duplicator_voice_allocator uut (.*);

   // clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("note_duplicator_voice_allocator regression: fail");
         $finish;
      end
   end

   // result side: sample at rising edge, stall at falling edge
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   task automatic write_reg(ndva_reg_type idx, logic [63:0] v);
      @(negedge clock);
      req_valid <= 0;
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= CSR_AW'(8 * int'(idx)); csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_reg(idx, v);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // send one word, holding valid through stalls; valid stays up for the next word
   task automatic send_word(ndva_req_type w);
      @(negedge clock);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(w);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic ndva_req_type rand_word(int stop_pct);
      ndva_req_type w;
      w.instrument = 8'($urandom);
      w.effect_cmd = 8'($urandom);
      w.effect_param = 8'($urandom);
      w.command = ($urandom_range(99) < stop_pct);
      w.channel = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      if ($urandom_range(3) == 0) w.note = 8'($urandom_range(255, 120));
      else w.note = 8'($urandom_range(119));
      return w;
   endfunction

   function automatic logic [55:0] rand_offsets();
      logic [55:0] o;
      for (int s = 0; s < 8; s++) o[7*s +: 7] = 7'($urandom);
      return o;
   endfunction

   function automatic logic [55:0] rand_targets(int span);
      logic [55:0] t;
      for (int s = 0; s < 8; s++) t[7*s +: 7] = 7'($urandom_range(span));
      return t;
   endfunction

   // stimulus
   initial begin
      ndva_req_type w;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, offsets at both ends, clamping, note commands
      write_reg(REG_ENABLE, 64'hFF);
      write_reg(REG_TARGET, {7'd127, 7'd0, 7'd1, 7'd1, 7'd5, 7'd5, 7'd0, 7'd127});
      write_reg(REG_OFFSET, {7'h3F, 7'h40, 7'd0, 7'd48, 7'h50, 7'd1, 7'h7F, 7'd0});
      write_reg(REG_MUTED, 0);
      send_word('{0, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00});
      send_word('{0, 6'd63, 8'd119, 8'hFF, 8'hFF, 8'hFF});
      send_word('{0, 6'd0, 8'd60, 8'hA5, 8'h5A, 8'h3C});
      send_word('{0, 6'd0, 8'd120, 8'h01, 8'h02, 8'h03});
      send_word('{0, 6'd63, 8'd255, 8'h80, 8'h40, 8'h20});
      send_word('{0, 6'd31, 8'd70, 8'h11, 8'h22, 8'h33});
      send_word('{1, 6'd31, 8'd70, 8'h11, 8'h22, 8'h33});
      send_word('{0, 6'd31, 8'd10, 8'h44, 8'h55, 8'h66});
      // fill every track of one machine, one voice per channel
      drain();
      write_reg(REG_ENABLE, 64'h01);
      write_reg(REG_TARGET, 56'd9);
      for (int c = 0; c < 64; c++) send_word('{0, 6'(c), 8'd64, 8'h0, 8'h0, 8'h0});
      send_word('{0, 6'd5, 8'd64, 8'h0, 8'h0, 8'h0}); // reused voice
      drain();
      write_reg(REG_ENABLE, 64'h03);
      write_reg(REG_TARGET, {49'd0, 7'd9});
      send_word('{0, 6'd7, 8'd50, 8'h0, 8'h0, 8'h0});
      send_word('{0, 6'd8, 8'd50, 8'h0, 8'h0, 8'h0});
      send_word('{0, 6'd7, 8'd121, 8'h0, 8'h0, 8'h0});
      // muted words produce nothing, stop still clears
      drain();
      write_reg(REG_MUTED, 1);
      send_word('{0, 6'd3, 8'd50, 8'h0, 8'h0, 8'h0});
      send_word('{1, 6'd3, 8'd50, 8'h0, 8'h0, 8'h0});
      drain();
      write_reg(REG_MUTED, 0);
      write_reg(REG_ENABLE, 0);
      send_word('{0, 6'd3, 8'd50, 8'h0, 8'h0, 8'h0});

      // random phases with different settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         send_idle = (ph % 4 == 1 || ph % 4 == 3) ? 47 : 0;
         recv_stall = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 25 : 0;
         if (ph % 4 == 3) send_idle = 25;
         write_reg(REG_ENABLE, (ph == 7) ? 64'hFF : 64'($urandom));
         write_reg(REG_TARGET, rand_targets((ph < 4) ? 3 : 127));
         write_reg(REG_OFFSET, rand_offsets());
         write_reg(REG_MUTED, (ph == 5) ? 64'd1 : 64'd0);
         if (ph == 2) hold_off = 300;
         for (int i = 0; i < 45; i++) begin
            w = rand_word(4);
            send_word(w);
         end
         if (ph == 4) begin
            drain();
            send_word(rand_word(0));
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("note_duplicator_voice_allocator regression: pass");
      else
         $display("note_duplicator_voice_allocator regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
